[rtl/core/stereo_decimating_fir_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the stereo decimating FIR
// Shared property wrappers for the checker, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef STEREO_DECIMATING_FIR_DEFINES_SVH
`define STEREO_DECIMATING_FIR_DEFINES_SVH

// Property checked only while out of reset
`define SDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property that also holds across the reset cycles
`define SDF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg
// Types, widths and constants shared by the stereo decimating FIR modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

    // Filter depth and derived widths
    localparam int MAX_TAPS = 64;
    localparam int TAP_W    = $clog2(MAX_TAPS);
    localparam int FILL_W   = $clog2(MAX_TAPS + 1);

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 6;
    localparam int DEC_W      = 5;
    localparam int TAPCFG_W   = 7;
    localparam int PHASE_W    = 4;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;

    // Compare widths that cover both a field and the filter depth
    localparam int CNT_W = (FILL_W > TAPCFG_W) ? FILL_W : TAPCFG_W;
    localparam int IDX_W = (FILL_W > COEF_IDX_W) ? FILL_W : COEF_IDX_W;

    // Stream packing
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int HIST_W     = 2 * SAMPLE_W;

    // Arithmetic
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = 40;
    localparam int FRAC_W = 15;
    localparam logic signed [ACC_W-1:0] Q_MAX = (2 ** (SAMPLE_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] Q_MIN = -(2 ** (SAMPLE_W - 1));
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (2 ** FRAC_W) - 1;

    // Register reset values and limits
    localparam logic [DEC_W-1:0]    DEC_RESET  = DEC_W'(1);
    localparam logic [DEC_W-1:0]    DEC_MAX    = DEC_W'(16);
    localparam logic [TAPCFG_W-1:0] TAPS_RESET = TAPCFG_W'(64);

    // Cycles from the last tap read until the accumulator holds the sum
    localparam int DRAIN_W = 2;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECIMATION = 1'b0,
        REG_TAP_COUNT  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Sequencer to MAC control
    typedef struct packed {
        logic clear;    // start a new sum
        logic valid;    // read data for one tap is present
        logic use_tap;  // both coefficient and history entry were written
    } mac_ctl_t;

endpackage

`default_nettype wire

[rtl/core/stereo_decimating_fir.sv]
// ----------------------------------------------------------------------------
// stereo_decimating_fir
// Stereo FIR filter with decimation, coefficient load and saturated output.
// ----------------------------------------------------------------------------
// A coefficient write or a dropped sample leaves the block ready. A kept
// sample is accepted, then a single multiply-accumulate pair walks the active
// taps one at a time through the coefficient and history memories, the
// product and accumulate pipeline drains, and the result state hands the sum
// to the output register; with tap_count at zero the walk and drain are
// skipped. s_tready is low while a sample is in work and while a finished
// result waits for a full output register. The output register holds one
// result, so one result may wait on m_tready while the next is accepted.
// Histories and coefficients count as zero after reset, with no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_decimating_fir (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample_left[15:0], sample_right[31:16], coef_index[37:32],
    // coef_value[53:38], zero padding[55:54]
    input  wire logic [sdf_pkg::IN_DATA_W-1:0]      s_tdata,
    // command[0]
    input  wire logic                              s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_left[15:0], out_right[31:16]
    output logic      [sdf_pkg::OUT_DATA_W-1:0]     m_tdata,
    // saturated[0]
    output logic                                   m_tuser,
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sdf_pkg::CFG_W-1:0]          cfg_data
);
    import sdf_pkg::*;

    logic                  coef_we;
    logic [TAP_W-1:0]      coef_waddr;
    logic [TAP_W-1:0]      coef_raddr;
    logic [COEF_W-1:0]     coef_rdata;
    logic                  hist_we;
    logic [TAP_W-1:0]      hist_waddr;
    logic [TAP_W-1:0]      hist_raddr;
    logic [HIST_W-1:0]     hist_rdata;
    mac_ctl_t              mac_ctl;
    logic                  out_free;
    logic                  out_load;
    logic [SAMPLE_W-1:0]   res_left;
    logic [SAMPLE_W-1:0]   res_right;
    logic                  res_sat;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_sat_reg;

    sdf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser),
        .coef_idx   (s_tdata[37:32]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_free   (out_free),
        .out_load   (out_load),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_raddr (coef_raddr),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_raddr (hist_raddr),
        .mac_ctl    (mac_ctl)
    );

    // Coefficient memory
    sdf_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_tdata[53:38]),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // Sample history, left in the low half and right in the high half
    sdf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (s_tdata[31:0]),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    sdf_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .coef       (signed'(coef_rdata)),
        .hist_left  (signed'(hist_rdata[SAMPLE_W-1:0])),
        .hist_right (signed'(hist_rdata[HIST_W-1:SAMPLE_W])),
        .res_left   (res_left),
        .res_right  (res_right),
        .res_sat    (res_sat)
    );

    // Output register: hold a result until the transaction completes
    assign out_free = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {res_right, res_left};
            out_sat_reg  <= res_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

`default_nettype wire

[rtl/core/sdf_ram.sv]
// ----------------------------------------------------------------------------
// sdf_ram
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/sdf_mac.sv]
// ----------------------------------------------------------------------------
// sdf_mac
// Shared stereo multiply-accumulate with truncating scale and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_mac (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sdf_pkg::mac_ctl_t                  ctl,
    input  wire logic signed [sdf_pkg::COEF_W-1:0]   coef,
    input  wire logic signed [sdf_pkg::SAMPLE_W-1:0] hist_left,
    input  wire logic signed [sdf_pkg::SAMPLE_W-1:0] hist_right,
    output logic signed      [sdf_pkg::SAMPLE_W-1:0] res_left,
    output logic signed      [sdf_pkg::SAMPLE_W-1:0] res_right,
    output logic                                    res_sat
);
    import sdf_pkg::*;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_left_reg;
    logic signed [PROD_W-1:0] prod_right_reg;
    logic signed [ACC_W-1:0]  acc_left_reg;
    logic signed [ACC_W-1:0]  acc_right_reg;
    logic signed [ACC_W-1:0]  q_left;
    logic signed [ACC_W-1:0]  q_right;
    logic                     clip_left;
    logic                     clip_right;

    // Product stage: zero the term for an entry never written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.use_tap) begin
            prod_left_reg  <= coef * hist_left;
            prod_right_reg <= coef * hist_right;
        end else begin
            prod_left_reg  <= '0;
            prod_right_reg <= '0;
        end
    end

    // Accumulate stage
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_left_reg  <= acc_left_reg + ACC_W'(prod_left_reg);
            acc_right_reg <= acc_right_reg + ACC_W'(prod_right_reg);
        end
    end

    // Shift right toward zero: bias negative sums before the arithmetic shift
    always_comb begin
        q_left  = $signed(acc_left_reg + (acc_left_reg[ACC_W-1] ? TRUNC_BIAS : '0))
                  >>> FRAC_W;
        q_right = $signed(acc_right_reg + (acc_right_reg[ACC_W-1] ? TRUNC_BIAS : '0))
                  >>> FRAC_W;
    end

    // Clip to the sample range
    always_comb begin
        clip_left  = 1'b1;
        clip_right = 1'b1;
        if (q_left > Q_MAX) begin
            res_left = SAMPLE_W'(Q_MAX);
        end else if (q_left < Q_MIN) begin
            res_left = SAMPLE_W'(Q_MIN);
        end else begin
            res_left  = q_left[SAMPLE_W-1:0];
            clip_left = 1'b0;
        end
        if (q_right > Q_MAX) begin
            res_right = SAMPLE_W'(Q_MAX);
        end else if (q_right < Q_MIN) begin
            res_right = SAMPLE_W'(Q_MIN);
        end else begin
            res_right  = q_right[SAMPLE_W-1:0];
            clip_right = 1'b0;
        end
        res_sat = clip_left | clip_right;
    end

endmodule

`default_nettype wire

[rtl/core/sdf_ctrl.sv]
// ----------------------------------------------------------------------------
// sdf_ctrl
// Sequencer: configuration, decimation phase, history pointer, tap loop.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input transaction
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic [sdf_pkg::COEF_IDX_W-1:0]      coef_idx,
    // Configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sdf_pkg::CFG_W-1:0]           cfg_data,
    // Result handoff
    input  wire logic                               out_free,
    output logic                                    out_load,
    // Memory control
    output logic                                    coef_we,
    output logic      [sdf_pkg::TAP_W-1:0]           coef_waddr,
    output logic      [sdf_pkg::TAP_W-1:0]           coef_raddr,
    output logic                                    hist_we,
    output logic      [sdf_pkg::TAP_W-1:0]           hist_waddr,
    output logic      [sdf_pkg::TAP_W-1:0]           hist_raddr,
    // MAC control
    output sdf_pkg::mac_ctl_t                        mac_ctl
);
    import sdf_pkg::*;

    state_t              state_reg, state_next;
    logic [DEC_W-1:0]    dec_reg;
    logic [TAPCFG_W-1:0] tap_count_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [TAP_W-1:0]    wp_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [MAX_TAPS-1:0] coef_valid_reg;
    logic [CNT_W-1:0]    taps_reg;
    logic [TAP_W-1:0]    k_reg, k_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;
    logic                rd_valid_reg;
    logic                use_reg;

    logic                accept;
    logic                is_coef;
    logic                keep;
    logic [DEC_W-1:0]    dec_eff;
    logic [PHASE_W:0]    phase_inc;
    logic [CNT_W-1:0]    taps_eff;
    logic [TAP_W-1:0]    wp_inc;
    logic [TAP_W:0]      hist_diff;
    logic                idx_ok;
    logic                issue;
    logic                last_tap;
    logic                hist_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign is_coef  = (cmd == CMD_COEF);

    // Clamp the registers to their working ranges
    always_comb begin
        if (dec_reg == '0) begin
            dec_eff = DEC_W'(1);
        end else if (dec_reg > DEC_MAX) begin
            dec_eff = DEC_MAX;
        end else begin
            dec_eff = dec_reg;
        end
        if (CNT_W'(tap_count_reg) > CNT_W'(MAX_TAPS)) begin
            taps_eff = CNT_W'(MAX_TAPS);
        end else begin
            taps_eff = CNT_W'(tap_count_reg);
        end
    end

    assign keep      = (phase_reg == '0);
    assign phase_inc = {1'b0, phase_reg} + (PHASE_W + 1)'(1);
    assign wp_inc    = (wp_reg == TAP_W'(MAX_TAPS - 1)) ? '0 : wp_reg + TAP_W'(1);
    assign idx_ok    = (IDX_W'(coef_idx) < IDX_W'(MAX_TAPS));

    // Coefficient and history writes happen in the accept cycle
    assign coef_we    = accept & is_coef & idx_ok;
    assign coef_waddr = TAP_W'(coef_idx);
    assign hist_we    = accept & ~is_coef & keep;
    assign hist_waddr = wp_inc;

    // Tap k reads coefficient k and the k-th newest history entry
    assign hist_diff  = {1'b0, wp_reg} - {1'b0, k_reg};
    assign coef_raddr = k_reg;
    always_comb begin
        if (hist_diff[TAP_W]) begin
            hist_raddr = TAP_W'(hist_diff + (TAP_W + 1)'(MAX_TAPS));
        end else begin
            hist_raddr = hist_diff[TAP_W-1:0];
        end
    end
    assign hist_ok  = (FILL_W'(k_reg) < fill_reg);
    assign last_tap = ((CNT_W'(k_reg) + CNT_W'(1)) == taps_reg);

    assign mac_ctl.clear   = hist_we;
    assign mac_ctl.valid   = rd_valid_reg;
    assign mac_ctl.use_tap = use_reg;

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (accept && !is_coef && keep) begin
                    state_next = (taps_eff == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                issue = 1'b1;
                if (last_tap) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + TAP_W'(1);
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and tap loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            drain_reg    <= '0;
            rd_valid_reg <= 1'b0;
            use_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            drain_reg    <= drain_next;
            rd_valid_reg <= issue;
            use_reg      <= issue & coef_valid_reg[k_reg] & hist_ok;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg       <= DEC_RESET;
            tap_count_reg <= TAPS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DECIMATION: dec_reg       <= cfg_data[DEC_W-1:0];
                REG_TAP_COUNT:  tap_count_reg <= cfg_data[TAPCFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Phase, history pointer, fill count and coefficient valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            coef_valid_reg <= '0;
            taps_reg       <= '0;
        end else if (accept) begin
            if (is_coef) begin
                if (idx_ok) begin
                    coef_valid_reg[coef_waddr] <= 1'b1;
                end
            end else begin
                if ((PHASE_W + 1)'(dec_eff) <= phase_inc) begin
                    phase_reg <= '0;
                end else begin
                    phase_reg <= phase_inc[PHASE_W-1:0];
                end
                if (keep) begin
                    wp_reg   <= wp_inc;
                    taps_reg <= taps_eff;
                    if (fill_reg != FILL_W'(MAX_TAPS)) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/sdf_checker.sv]
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level assertions for the stereo decimating FIR, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_decimating_fir_defines.svh"

module sdf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    logic rail_hit;

    // Either channel sits at a rail of the sample range
    assign rail_hit = (m_tdata[15:0] == 16'h7fff) || (m_tdata[15:0] == 16'h8000) ||
                      (m_tdata[31:16] == 16'h7fff) || (m_tdata[31:16] == 16'h8000);

    // Hold a stalled result
    `SDF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Flag a clipped result only when a channel sits at a rail
    `SDF_ASSERT(a_sat_rail, m_tvalid && m_tuser |-> rail_hit, "flag without a clipped channel")

    // A coefficient write leaves the input side ready
    `SDF_ASSERT(a_coef_ready, s_tvalid && s_tready && s_tuser |=> s_tready, "not ready after coefficient write")

    // A new result appears only after the sequencer has held the input side not ready
    `SDF_ASSERT(a_result_from_work, $rose(m_tvalid) |-> $past(!s_tready), "result without a sequenced pass")

    // Drop any result at reset
    `SDF_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result present after reset")

endmodule

bind stereo_decimating_fir sdf_checker u_sdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
